FILE: design/qrs_pkg.sv
package qrs_pkg;

  // Fixed output word width of every root field
  localparam int unsigned OutWidth = 48;

endpackage

FILE: design/qrs_sqrt.sv
// Pipelined restoring square root: one result bit per stage.
// Radicand is an unsigned DW-bit value; root has RW = DW/2 bits.
// A side word of SW bits travels with each entry.
module qrs_sqrt #(
  parameter int unsigned DW = 64,
  parameter int unsigned SW = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [DW-1:0]       rad_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [DW/2-1:0]     root_o,
  output logic [SW-1:0]       side_o
);

  localparam int unsigned RW = DW / 2;

  logic            vld_q  [1:RW];
  logic [DW-1:0]   rad_q  [1:RW];
  logic [RW-1:0]   root_q [1:RW];
  logic [RW+1:0]   rem_q  [1:RW];
  logic [SW-1:0]   side_q [1:RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic          vld_c;
    logic [DW-1:0] rad_c;
    logic [RW-1:0] root_c;
    logic [RW+1:0] rem_c, rem_sh, trial;
    logic [SW-1:0] side_c;
    logic          take;

    // Stage zero loads the radicand, later stages take the previous register
    if (s == 0) begin : g_load
      assign vld_c  = valid_i;
      assign rad_c  = rad_i;
      assign root_c = '0;
      assign rem_c  = '0;
      assign side_c = side_i;
    end else begin : g_chain
      assign vld_c  = vld_q[s];
      assign rad_c  = rad_q[s];
      assign root_c = root_q[s];
      assign rem_c  = rem_q[s];
      assign side_c = side_q[s];
    end

    always_comb begin
      rem_sh = {rem_c[RW-1:0], rad_c[DW-1 -: 2]};
      trial  = {root_c, 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s+1]  <= {rad_c[DW-3:0], 2'b00};
        rem_q[s+1]  <= take ? rem_sh - trial : rem_sh;
        root_q[s+1] <= {root_c[RW-2:0], take};
        side_q[s+1] <= side_c;
      end
    end
  end

  assign valid_o = vld_q[RW];
  assign root_o  = root_q[RW];
  assign side_o  = side_q[RW];

endmodule

FILE: design/qrs_div.sv
// Pipelined signed divider, truncating toward zero, one quotient bit per stage.
// Numerators are NW bits signed, divisor DW bits signed and nonzero.
module qrs_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 18,
  parameter int unsigned SW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic signed [NW-1:0] quo_o,
  output logic [SW-1:0]        side_o
);

  logic          vld_q  [1:NW];
  logic [NW-1:0] nm_q   [1:NW];
  logic [DW-1:0] dm_q   [1:NW];
  logic [DW:0]   rem_q  [1:NW];
  logic [NW-1:0] quo_q  [1:NW];
  logic          neg_q  [1:NW];
  logic [SW-1:0] side_q [1:NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          vld_c, neg_c;
    logic [NW-1:0] nm_c, quo_c;
    logic [DW-1:0] dm_c;
    logic [DW:0]   rem_c, rem_sh;
    logic [SW-1:0] side_c;
    logic          take;

    // Magnitudes and result sign enter stage zero
    if (s == 0) begin : g_load
      assign vld_c  = valid_i;
      assign nm_c   = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      assign dm_c   = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
      assign rem_c  = '0;
      assign quo_c  = '0;
      assign neg_c  = num_i[NW-1] ^ den_i[DW-1];
      assign side_c = side_i;
    end else begin : g_chain
      assign vld_c  = vld_q[s];
      assign nm_c   = nm_q[s];
      assign dm_c   = dm_q[s];
      assign rem_c  = rem_q[s];
      assign quo_c  = quo_q[s];
      assign neg_c  = neg_q[s];
      assign side_c = side_q[s];
    end

    always_comb begin
      rem_sh = {rem_c[DW-1:0], nm_c[NW-1]};
      take   = rem_sh >= {1'b0, dm_c};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nm_q[s+1]   <= nm_c << 1;
        dm_q[s+1]   <= dm_c;
        rem_q[s+1]  <= take ? rem_sh - {1'b0, dm_c} : rem_sh;
        quo_q[s+1]  <= {quo_c[NW-2:0], take};
        neg_q[s+1]  <= neg_c;
        side_q[s+1] <= side_c;
      end
    end
  end

  assign valid_o = vld_q[NW];
  assign quo_o   = neg_q[NW] ? -$signed(quo_q[NW]) : $signed(quo_q[NW]);
  assign side_o  = side_q[NW];

endmodule

FILE: design/quadratic_root_solver.sv
// Quadratic root solver: roots of a*x^2+b*x+c in signed fixed point with
// FRAC_BITS fraction bits. One coefficient word is taken every cycle while the
// pipeline is not stalled. A word passes 2 + (COEF_WIDTH + FRAC_BITS + 2) + 1 +
// (COEF_WIDTH + FRAC_BITS + 5) + 1 register stages (75 at the defaults), set by
// the bit-per-stage square root and divider pipelines. The whole pipeline
// stalls while a result waits at the output; a one-word skid register takes one
// more word during that wait, after which the input is held off until the
// output drains.
module quadratic_root_solver #(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [COEF_WIDTH-1:0]       coef_a_i,
  input  logic signed [COEF_WIDTH-1:0]       coef_b_i,
  input  logic signed [COEF_WIDTH-1:0]       coef_c_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [qrs_pkg::OutWidth-1:0] root1_real_o,
  output logic signed [qrs_pkg::OutWidth-1:0] root1_imag_o,
  output logic signed [qrs_pkg::OutWidth-1:0] root2_real_o,
  output logic signed [qrs_pkg::OutWidth-1:0] root2_imag_o,
  output logic                               roots_are_real_o,
  output logic                               degenerate_o
);

  localparam int unsigned CW = COEF_WIDTH;
  localparam int unsigned DW = 2 * CW + 3;             // discriminant width
  localparam int unsigned RADW = 2 * ((DW + 2 * FRAC_BITS + 1) / 2);
  localparam int unsigned RTW = RADW / 2;              // root width
  localparam int unsigned NW = CW + FRAC_BITS + 2 > RTW + 2 ?
                               CW + FRAC_BITS + 2 : RTW + 2;
  localparam int unsigned NUMW = NW + 1;
  localparam int unsigned DENW = CW + 1;
  localparam int unsigned OW = qrs_pkg::OutWidth;
  // side word: den, -b scaled, real flag, degenerate flag
  localparam int unsigned SSW = DENW + NUMW + 2;
  // divider side: real, degen, selector
  localparam int unsigned DSW = 3;

  // ---- input skid and pipeline enable ----
  logic                 skid_vld_q;
  logic [3*CW-1:0]      skid_q;
  logic                 en;
  logic                 out_vld_q;
  logic                 src_vld;
  logic [3*CW-1:0]      src;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = !skid_vld_q;
  assign src_vld    = skid_vld_q || in_valid_i;
  assign src        = skid_vld_q ? skid_q : {coef_a_i, coef_b_i, coef_c_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en) begin
      skid_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_valid_i && in_ready_o) begin
      skid_q <= {coef_a_i, coef_b_i, coef_c_i};
    end
  end

  // ---- stage 1: products ----
  logic                 s1_vld_q;
  logic signed [DW-1:0] s1_bb_q, s1_ac_q;
  logic signed [CW-1:0] s1_a_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= src_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_bb_q <= DW'($signed(src[2*CW-1:CW]) * $signed(src[2*CW-1:CW]));
      s1_ac_q <= DW'($signed(src[3*CW-1:2*CW]) * $signed(src[CW-1:0]));
      s1_a_q  <= $signed(src[3*CW-1:2*CW]);
      s1_b_q  <= $signed(src[2*CW-1:CW]);
    end
  end

  // ---- stage 2: discriminant, magnitude, scaled terms ----
  logic                 s2_vld_q;
  logic [RADW-1:0]      s2_rad_q;
  logic [SSW-1:0]       s2_side_q;
  logic signed [DW-1:0] disc;

  always_comb begin
    disc = s1_bb_q - (s1_ac_q <<< 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_rad_q <= RADW'(disc[DW-1] ? -disc : disc) << (2 * FRAC_BITS);
      s2_side_q <= {DENW'(s1_a_q) <<< 1,
                    NUMW'(-(NUMW'(s1_b_q))) << FRAC_BITS,
                    !disc[DW-1], s1_a_q == '0};
    end
  end

  // ---- square root ----
  logic           sq_vld;
  logic [RTW-1:0] sq_root;
  logic [SSW-1:0] sq_side;

  qrs_sqrt #(.DW(RADW), .SW(SSW)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s2_vld_q), .rad_i(s2_rad_q),
    .side_i(s2_side_q), .valid_o(sq_vld), .root_o(sq_root), .side_o(sq_side)
  );

  // ---- stage 3: two numerators ----
  logic                   s3_vld_q;
  logic signed [NUMW-1:0] s3_n1_q, s3_n2_q;
  logic signed [DENW-1:0] s3_den_q;
  logic                   s3_real_q, s3_deg_q;
  logic signed [NUMW-1:0] nb, sr;

  always_comb begin
    nb = $signed(sq_side[NUMW+1:2]);
    sr = $signed(NUMW'(sq_root));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_real_q <= sq_side[1];
      s3_deg_q  <= sq_side[0];
      s3_den_q  <= sq_side[0] ? DENW'(1) : $signed(sq_side[SSW-1 -: DENW]);
      s3_n1_q   <= sq_side[1] ? nb + sr : nb;
      s3_n2_q   <= sq_side[1] ? nb - sr : sr;
    end
  end

  // ---- two dividers ----
  logic                   d1_vld, d2_vld;
  logic signed [NUMW-1:0] q1, q2;
  logic [DSW-1:0]         d1_side, d2_side;

  qrs_div #(.NW(NUMW), .DW(DENW), .SW(DSW)) u_div1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s3_vld_q), .num_i(s3_n1_q),
    .den_i(s3_den_q), .side_i({s3_real_q, s3_deg_q, 1'b0}),
    .valid_o(d1_vld), .quo_o(q1), .side_o(d1_side)
  );

  qrs_div #(.NW(NUMW), .DW(DENW), .SW(DSW)) u_div2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s3_vld_q), .num_i(s3_n2_q),
    .den_i(s3_den_q), .side_i({s3_real_q, s3_deg_q, 1'b1}),
    .valid_o(d2_vld), .quo_o(q2), .side_o(d2_side)
  );

  // ---- output register ----
  logic signed [OW-1:0] q1w, q2w;
  logic                 rl, dg;

  always_comb begin
    q1w = OW'(q1);
    q2w = OW'(q2);
    rl  = d1_side[2];
    dg  = d1_side[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roots_are_real_o <= rl;
      degenerate_o     <= dg;
      if (dg) begin
        root1_real_o <= '0;
        root1_imag_o <= '0;
        root2_real_o <= '0;
        root2_imag_o <= '0;
      end else if (rl) begin
        root1_real_o <= q1w;
        root1_imag_o <= '0;
        root2_real_o <= q2w;
        root2_imag_o <= '0;
      end else begin
        root1_real_o <= q1w;
        root1_imag_o <= q2w;
        root2_real_o <= q1w;
        root2_imag_o <= -q2w;
      end
    end
  end

  assign out_valid_o = out_vld_q;

  // ---- assertions ----
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d1_vld == d2_vld) else $error("divider lanes out of step");

  a_lane_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d1_vld |-> (!d1_side[0] && d2_side[0])) else $error("lane tags swapped");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (root1_real_o == '0 && root2_real_o == '0
      && roots_are_real_o)) else $error("degenerate word not cleared");

  a_skid_only_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> $past(!en)) else $error("skid filled without stall");

endmodule
